/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

	// queue geometry
	localparam int DEPTH = 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// field widths
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 4;
	localparam int ENTRY_W  = DATA_W + PRIO_W;

	// opcodes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// one finished result
	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] head_data;
		logic [PRIO_W-1:0]        head_priority;
		logic                     head_valid;
		logic [FILL_W-1:0]        fill_count;
	} res_t;

endpackage

`default_nettype wire

/* rtl/spq_ram.sv */
`default_nettype none

module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/spq_core.sv */
`default_nettype none

module spq_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic                               op,
	input  wire logic signed [spq_pkg::DATA_W-1:0]  data_in,
	input  wire logic [spq_pkg::PRIO_W-1:0]         prio_in,
	input  wire logic                               res_take,
	output logic                                    idle,
	output logic                                    res_ready,
	output spq_pkg::res_t                           res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EX   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]                          state_q;
	logic                                op_q;
	logic signed [spq_pkg::DATA_W-1:0]   data_q;
	logic [spq_pkg::PRIO_W-1:0]          prio_q;
	logic [spq_pkg::CNT_W-1:0]           idx_q;
	logic [spq_pkg::CNT_W-1:0]           count_q;
	logic signed [spq_pkg::DATA_W-1:0]   head_data_q;
	logic [spq_pkg::PRIO_W-1:0]          head_prio_q;
	logic [spq_pkg::STATUS_W-1:0]        status_q;
	logic signed [spq_pkg::DATA_W-1:0]   res_data_q;
	logic [spq_pkg::PRIO_W-1:0]          res_prio_q;
	logic                                res_valid_q;

	logic [spq_pkg::CNT_W-1:0]           idx_m1;
	logic [spq_pkg::CNT_W-1:0]           idx_p1;
	logic                                we;
	logic [spq_pkg::IDX_W-1:0]           waddr;
	logic [spq_pkg::IDX_W-1:0]           raddr;
	logic [spq_pkg::ENTRY_W-1:0]         wdata;
	logic [spq_pkg::ENTRY_W-1:0]         rd_word;
	logic signed [spq_pkg::DATA_W-1:0]   rd_data;
	logic [spq_pkg::PRIO_W-1:0]          rd_prio;
	logic                                move_down;

	assign idx_m1  = idx_q - spq_pkg::CNT_W'(1);
	assign idx_p1  = idx_q + spq_pkg::CNT_W'(1);
	assign rd_data = rd_word[spq_pkg::DATA_W-1:0];
	assign rd_prio = rd_word[spq_pkg::ENTRY_W-1:spq_pkg::DATA_W];

	// shared compare: new entry goes ahead of lower or equal priorities
	assign move_down = (prio_q >= rd_prio);

	// slot store
	spq_ram #(
		.WIDTH(spq_pkg::ENTRY_W),
		.DEPTH(spq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_word)
	);

	// enqueue walks down from the tail, dequeue walks up from slot one
	assign raddr = (op_q == spq_pkg::OP_ENQ) ? idx_m1[spq_pkg::IDX_W-1:0]
	                                         : idx_q[spq_pkg::IDX_W-1:0];

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[spq_pkg::IDX_W-1:0];
		wdata = rd_word;
		case (state_q)
			S_EX: begin
				if (op_q == spq_pkg::OP_ENQ) begin
					we = move_down;
				end else begin
					we    = 1'b1;
					waddr = idx_m1[spq_pkg::IDX_W-1:0];
				end
			end
			S_WR: begin
				we    = 1'b1;
				wdata = {prio_q, data_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= spq_pkg::OP_ENQ;
			data_q      <= '0;
			prio_q      <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			head_data_q <= '0;
			head_prio_q <= '0;
			status_q    <= spq_pkg::ST_OK;
			res_data_q  <= '0;
			res_prio_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= op;
						data_q <= data_in;
						prio_q <= prio_in;
						if (op == spq_pkg::OP_ENQ) begin
							if (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
								status_q    <= spq_pkg::ST_FULL;
								res_data_q  <= head_data_q;
								res_prio_q  <= head_prio_q;
								res_valid_q <= 1'b1;
								state_q     <= S_DONE;
							end else begin
								idx_q   <= count_q;
								state_q <= (count_q == '0) ? S_WR : S_RD;
							end
						end else begin
							if (count_q == '0) begin
								status_q    <= spq_pkg::ST_EMPTY;
								res_data_q  <= '0;
								res_prio_q  <= '0;
								res_valid_q <= 1'b0;
								state_q     <= S_DONE;
							end else begin
								status_q    <= spq_pkg::ST_OK;
								res_data_q  <= head_data_q;
								res_prio_q  <= head_prio_q;
								res_valid_q <= 1'b1;
								idx_q       <= spq_pkg::CNT_W'(1);
								if (count_q == spq_pkg::CNT_W'(1)) begin
									count_q <= '0;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					if (op_q == spq_pkg::OP_ENQ) begin
						if (move_down) begin
							idx_q   <= idx_m1;
							state_q <= (idx_m1 == '0) ? S_WR : S_RD;
						end else begin
							state_q <= S_WR;
						end
					end else begin
						if (idx_q == spq_pkg::CNT_W'(1)) begin
							head_data_q <= rd_data;
							head_prio_q <= rd_prio;
						end
						idx_q <= idx_p1;
						if (idx_p1 == count_q) begin
							count_q <= count_q - spq_pkg::CNT_W'(1);
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_WR: begin
					count_q     <= count_q + spq_pkg::CNT_W'(1);
					status_q    <= spq_pkg::ST_OK;
					res_valid_q <= 1'b1;
					if (idx_q == '0) begin
						head_data_q <= data_q;
						head_prio_q <= prio_q;
						res_data_q  <= data_q;
						res_prio_q  <= prio_q;
					end else begin
						res_data_q  <= head_data_q;
						res_prio_q  <= head_prio_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result out
	assign idle              = (state_q == S_IDLE);
	assign res_ready         = (state_q == S_DONE);
	assign res.status        = status_q;
	assign res.head_data     = res_data_q;
	assign res.head_priority = res_prio_q;
	assign res.head_valid    = res_valid_q;
	assign res.fill_count    = spq_pkg::FILL_W'(count_q);

	// fill count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
		else $error("fill count above capacity");

	// the walk index stays inside the filled region
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_EX) |-> (idx_q <= count_q && idx_q != '0))
		else $error("walk index out of range");

	// a full rejection only happens at capacity
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ready && status_q == spq_pkg::ST_FULL) |->
		(count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH) && res_valid_q))
		else $error("full status below capacity");

	// an empty dequeue reports no head and an empty queue
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ready && status_q == spq_pkg::ST_EMPTY) |->
		(!res_valid_q && res_data_q == '0 && count_q == '0))
		else $error("bad empty dequeue result");

	// an accepted beat always leaves idle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && start) |=> !idle)
		else $error("accepted beat not started");

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue_unit.sv */
// Sorted priority queue of spq_pkg::DEPTH entries (32-bit data, 8-bit priority).
// Input beats on the s_ stream: s_tuser is the opcode (0 enqueue, 1 dequeue),
// s_tdata carries the entry to insert. Every input beat gives exactly one
// output beat on the m_ stream with the status, the head entry (the removed
// entry on a dequeue) and the fill count after the operation.
// Entries sit sorted by descending priority in a single-port-write RAM; one
// comparator and the RAM's one read port walk the array one slot at a time.
// Equal priorities leave last-in first-out.
// Handshake: s_tready is high only while the sequencer is idle. An enqueue
// walks down from the tail, reading and comparing each slot and moving lower
// or equal entries down a slot, then writes the new entry; a dequeue walks
// up from slot one, moving each entry up a slot; the full and empty
// rejections skip the walk. The sequencer returns to idle at the edge that
// loads the output register; the next input beat can be accepted in the cycle after that edge.
// The output register holds a finished beat while m_tready is low; the next
// input beat is accepted meanwhile and its result waits in the sequencer
// until the output register frees up.
// Reset (arst_n low) empties the queue and drops m_tvalid; slot contents are
// not cleared, only slots below the fill count are ever read.
`default_nettype none

module sorted_priority_queue_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // entry_data[31:0], entry_priority[39:32]
	input  wire logic        s_tuser,  // opcode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // head_data[31:0], head_priority[39:32],
	                                   // fill_count[43:40], zero[47:44]
	output logic [2:0]       m_tuser   // status[1:0], head_valid[2]
);

	logic          core_idle;
	logic          core_ready;
	logic          res_take;
	spq_pkg::res_t core_res;
	logic          m_tvalid_q;
	logic [47:0]   m_tdata_q;
	logic [2:0]    m_tuser_q;

	assign s_tready = core_idle;
	assign res_take = core_ready && (!m_tvalid_q || m_tready);

	// sequencer with slot store
	spq_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && core_idle),
		.op       (s_tuser),
		.data_in  (s_tdata[spq_pkg::DATA_W-1:0]),
		.prio_in  (s_tdata[spq_pkg::ENTRY_W-1:spq_pkg::DATA_W]),
		.res_take (res_take),
		.idle     (core_idle),
		.res_ready(core_ready),
		.res      (core_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {4'b0000, core_res.fill_count, core_res.head_priority,
			              core_res.head_data};
			m_tuser_q <= {core_res.head_valid, core_res.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

/* dv/tb_sorted_priority_queue_unit.sv */
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;

	localparam int RUN_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASES        = 14;
	localparam int PHASE_ITEMS   = 100;

	// one row of the directed stimulus table
	typedef struct {
		logic                              op;
		logic signed [spq_pkg::DATA_W-1:0] data;
		logic [spq_pkg::PRIO_W-1:0]        prio;
		bit                                typed;
		spq_pkg::res_t                     want;
	} stim_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [spq_pkg::ENTRY_W-1:0] s_tdata = '0;   // entry_data[31:0], entry_priority[39:32]
	logic                        s_tuser = 1'b0; // opcode[0]
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [47:0]                 m_tdata;        // head_data[31:0], head_priority[39:32],
	                                             // fill_count[43:40], zero[47:44]
	logic [2:0]                  m_tuser;        // status[1:0], head_valid[2]

	// shadow copy of the queue contents
	logic signed [spq_pkg::DATA_W-1:0] q_data [spq_pkg::DEPTH];
	logic [spq_pkg::PRIO_W-1:0]        q_prio [spq_pkg::DEPTH];
	int                                q_count = 0;

	spq_pkg::res_t pending_results [$];
	stim_row_t     stim_rows [$];
	int            errors = 0;
	int            cycles = 0;
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	int            rx_hold = 0;

	sorted_priority_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(0, 3);
	endfunction

	function automatic spq_pkg::res_t mk_res(logic [spq_pkg::STATUS_W-1:0] st,
			logic signed [spq_pkg::DATA_W-1:0] d, logic [spq_pkg::PRIO_W-1:0] p,
			logic v, logic [spq_pkg::FILL_W-1:0] fill);
		spq_pkg::res_t r;
		r.status        = st;
		r.head_data     = d;
		r.head_priority = p;
		r.head_valid    = v;
		r.fill_count    = fill;
		return r;
	endfunction

	// apply one operation to the shadow queue and return the beat it should produce
	function automatic spq_pkg::res_t queue_step(logic op,
			logic signed [spq_pkg::DATA_W-1:0] d, logic [spq_pkg::PRIO_W-1:0] p);
		spq_pkg::res_t r;
		int            pos;
		r = '0;
		if (op == spq_pkg::OP_ENQ) begin
			if (q_count >= spq_pkg::DEPTH) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				// insert ahead of every entry with lower or equal priority
				pos = 0;
				while (pos < q_count && p < q_prio[pos])
					pos++;
				for (int i = q_count; i > pos; i--) begin
					q_data[i] = q_data[i-1];
					q_prio[i] = q_prio[i-1];
				end
				q_data[pos] = d;
				q_prio[pos] = p;
				q_count++;
				r.status = spq_pkg::ST_OK;
			end
			r.head_data     = q_data[0];
			r.head_priority = q_prio[0];
			r.head_valid    = 1'b1;
		end else if (q_count == 0) begin
			r.status = spq_pkg::ST_EMPTY;
		end else begin
			// report the removed head, then close the gap
			r.status        = spq_pkg::ST_OK;
			r.head_data     = q_data[0];
			r.head_priority = q_prio[0];
			r.head_valid    = 1'b1;
			for (int i = 1; i < q_count; i++) begin
				q_data[i-1] = q_data[i];
				q_prio[i-1] = q_prio[i];
			end
			q_count--;
		end
		r.fill_count = spq_pkg::FILL_W'(q_count);
		return r;
	endfunction

	// present one beat, wait for the handshake, log the expected result
	task automatic send_beat(logic op, logic signed [spq_pkg::DATA_W-1:0] d,
			logic [spq_pkg::PRIO_W-1:0] p, bit typed, spq_pkg::res_t want);
		int            gap;
		spq_pkg::res_t predicted;
		gap = ($urandom_range(0, 99) < tx_idle_pct) ? gap_len() + 1 : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p, d};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		predicted = queue_step(op, d, p);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < rx_stall_pct) begin
			rx_hold  <= gap_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		spq_pkg::res_t got;
		spq_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status        = m_tuser[1:0];
			got.head_valid    = m_tuser[2];
			got.head_data     = m_tdata[31:0];
			got.head_priority = m_tdata[39:32];
			got.fill_count    = m_tdata[43:40];
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat status=%0d data=%0d prio=%0d fill=%0d",
					$time, got.status, got.head_data, got.head_priority, got.fill_count);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				end
				if (got.head_data !== want.head_data) begin
					errors++;
					$display("%0t: head_data exp %0d got %0d", $time,
						want.head_data, got.head_data);
				end
				if (got.head_priority !== want.head_priority) begin
					errors++;
					$display("%0t: head_priority exp %0d got %0d", $time,
						want.head_priority, got.head_priority);
				end
				if (got.head_valid !== want.head_valid) begin
					errors++;
					$display("%0t: head_valid exp %0d got %0d", $time,
						want.head_valid, got.head_valid);
				end
				if (got.fill_count !== want.fill_count) begin
					errors++;
					$display("%0t: fill_count exp %0d got %0d", $time,
						want.fill_count, got.fill_count);
				end
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("tb_sorted_priority_queue_unit NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t                         row;
		spq_pkg::res_t                     none;
		int                                enq_pct;
		int                                prio_mode;
		logic                              op;
		logic signed [spq_pkg::DATA_W-1:0] d;
		logic [spq_pkg::PRIO_W-1:0]        p;

		none = '0;

		// directed table: extremes, ties, full and empty corners
		stim_rows.push_back('{spq_pkg::OP_DEQ, 32'sh0, 8'd0, 1'b1,
			mk_res(spq_pkg::ST_EMPTY, 32'sh0, 8'd0, 1'b0, 4'd0)});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh7FFFFFFF, 8'd255, 1'b1,
			mk_res(spq_pkg::ST_OK, 32'sh7FFFFFFF, 8'd255, 1'b1, 4'd1)});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh80000000, 8'd0, 1'b1,
			mk_res(spq_pkg::ST_OK, 32'sh7FFFFFFF, 8'd255, 1'b1, 4'd2)});
		// tie at the top: the newest entry becomes the head
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh1, 8'd255, 1'b1,
			mk_res(spq_pkg::ST_OK, 32'sh1, 8'd255, 1'b1, 4'd3)});
		stim_rows.push_back('{spq_pkg::OP_ENQ, -32'sh1, 8'd0, 1'b0, none});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh0, 8'd128, 1'b0, none});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh5555AAAA, 8'd128, 1'b0, none});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'shAAAA5555, 8'd1, 1'b0, none});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh12345678, 8'd254, 1'b0, none});
		// full: rejected, head still shown
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh0F0F0F0F, 8'd255, 1'b0, none});
		stim_rows.push_back('{spq_pkg::OP_DEQ, 32'shFFFFFFFF, 8'd255, 1'b0, none});
		// the slot freed by the dequeue gets reused; the next enqueue finds the queue full
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh13579BDF, 8'd200, 1'b0, none});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'shF0F0F0F0, 8'd0, 1'b0, none});
		for (int i = 0; i < spq_pkg::DEPTH; i++)
			stim_rows.push_back('{spq_pkg::OP_DEQ, 32'sh0, 8'd0, 1'b0, none});
		stim_rows.push_back('{spq_pkg::OP_DEQ, 32'sh0, 8'd0, 1'b1,
			mk_res(spq_pkg::ST_EMPTY, 32'sh0, 8'd0, 1'b0, 4'd0)});
		stim_rows.push_back('{spq_pkg::OP_ENQ, 32'sh2A, 8'd7, 1'b1,
			mk_res(spq_pkg::ST_OK, 32'sh2A, 8'd7, 1'b1, 4'd1)});
		stim_rows.push_back('{spq_pkg::OP_DEQ, 32'sh0, 8'd0, 1'b1,
			mk_res(spq_pkg::ST_OK, 32'sh2A, 8'd7, 1'b1, 4'd0)});
		stim_rows.push_back('{spq_pkg::OP_DEQ, 32'sh0, 8'd0, 1'b1,
			mk_res(spq_pkg::ST_EMPTY, 32'sh0, 8'd0, 1'b0, 4'd0)});

		// reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct  = 30;
		rx_stall_pct = 20;
		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			send_beat(row.op, row.data, row.prio, row.typed, row.want);
		end

		// random phases with varying mix, priority spread and idling
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: enq_pct = 15;
				1: enq_pct = 50;
				2: enq_pct = 70;
				default: enq_pct = 90;
			endcase
			prio_mode = $urandom_range(0, 2);
			case (ph % 3)
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 30;
				default: tx_idle_pct = 70;
			endcase
			case ($urandom_range(0, 2))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 20;
				default: rx_stall_pct = 60;
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
				case ($urandom_range(0, 7))
					0: d = 32'sh80000000;
					1: d = 32'sh7FFFFFFF;
					default: d = $urandom;
				endcase
				case (prio_mode)
					0: p = spq_pkg::PRIO_W'($urandom_range(0, 255));
					1: p = spq_pkg::PRIO_W'($urandom_range(0, 3));
					default: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				endcase
				send_beat(op, d, p, 1'b0, none);
			end
		end
		s_tvalid <= 1'b0;

		// drain
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("tb_sorted_priority_queue_unit OK");
		end else begin
			$display("tb_sorted_priority_queue_unit NOT OK");
		end
		$finish;
	end

endmodule
